// ----- sv/rld_pkg.sv -----
`default_nettype none

package rld_pkg;

    localparam int unsigned RLD_MAX_RUNS = 128;

    // Largest byte count that a header nibble may give.
    localparam logic [3:0] RLD_NIB_MAX = 4'd8;

    // A header of all zeros ends the list.
    localparam logic [7:0] RLD_HDR_END = 8'h00;

    // Highest run number that a 7-bit field can carry.
    localparam int unsigned RLD_RUN_NUM_MAX = 127;

    typedef struct packed {
        logic [7:0] run_byte;
        logic       list_start;
    } item_t;

endpackage

`default_nettype wire

// ----- sv/rld_in_if.sv -----
`default_nettype none

interface rld_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] run_byte;
    logic       list_start;

    modport source (
        output valid,
        output run_byte,
        output list_start,
        input  ready
    );

    modport sink (
        input  valid,
        input  run_byte,
        input  list_start,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/rld_out_if.sv -----
`default_nettype none

interface rld_out_if;
    logic               valid;
    logic               ready;
    logic [63:0]        run_length;
    logic signed [63:0] run_start_cluster;
    logic [6:0]         run_number;
    logic               sparse_run;
    logic               list_end;
    logic               bad_header;

    modport source (
        output valid,
        output run_length,
        output run_start_cluster,
        output run_number,
        output sparse_run,
        output list_end,
        output bad_header,
        input  ready
    );

    modport sink (
        input  valid,
        input  run_length,
        input  run_start_cluster,
        input  run_number,
        input  sparse_run,
        input  list_end,
        input  bad_header,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/rld_in_stage.sv -----
`default_nettype none

module rld_in_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    rld_in_if.sink              run_in,
    input  wire logic           item_take,
    output rld_pkg::item_t      item,
    output logic                item_valid
);

    logic           valid_reg;
    rld_pkg::item_t item_reg;
    logic           load;

    // The register refills whenever it is empty or its item moves on this cycle.
    assign load         = !valid_reg || item_take;
    assign run_in.ready = load;
    assign item         = item_reg;
    assign item_valid   = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= run_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && run_in.valid)
        begin
            item_reg.run_byte   <= run_in.run_byte;
            item_reg.list_start <= run_in.list_start;
        end
    end

endmodule

`default_nettype wire

// ----- sv/rld_core.sv -----
`default_nettype none

module rld_core #(
    parameter logic [6:0] RUN_CAP = 7'd127
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire rld_pkg::item_t item,
    input  wire logic           item_valid,
    output logic                item_take,
    rld_out_if.source           run_out
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_OFFSET,
        PH_IDLE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  len_left_reg, len_left_next;
    logic [3:0]  off_left_reg, off_left_next;
    logic [3:0]  off_total_reg, off_total_next;
    logic [2:0]  pos_reg, pos_next;
    logic [63:0] len_acc_reg, len_acc_next;
    logic [63:0] delta_acc_reg, delta_acc_next;
    logic [63:0] cluster_reg, cluster_next;
    logic [6:0]  counter_reg, counter_next;

    logic               out_valid_reg, out_valid_next;
    logic [63:0]        out_len_reg, out_len_next;
    logic signed [63:0] out_start_reg, out_start_next;
    logic [6:0]         out_num_reg, out_num_next;
    logic               out_sparse_reg, out_sparse_next;
    logic               out_end_reg, out_end_next;
    logic               out_bad_reg, out_bad_next;

    logic        fire;
    phase_t      ph;
    logic [7:0]  b;
    logic [3:0]  lnib;
    logic [3:0]  onib;
    logic [6:0]  counter_base;
    logic [63:0] cluster_base;
    logic [63:0] byte_shifted;
    logic [63:0] delta;
    logic [6:0]  counter_adv;

    assign item_take = !out_valid_reg || run_out.ready;
    assign fire      = item_valid && item_take;

    assign b    = item.run_byte;
    assign lnib = b[3:0];
    assign onib = b[7:4];

    assign ph           = item.list_start ? PH_HEADER : phase_reg;
    assign counter_base = item.list_start ? 7'd0 : counter_reg;
    assign cluster_base = item.list_start ? 64'd0 : cluster_reg;
    assign counter_adv  = (counter_base < RUN_CAP) ? counter_base + 7'd1 : counter_base;

    assign byte_shifted = {56'd0, b} << {pos_reg, 3'b000};

    // The last offset byte is the top byte of the delta; lanes above it take its sign.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            if (3'(i) < pos_reg)
            begin
                delta[8*i +: 8] = delta_acc_reg[8*i +: 8];
            end
            else if (3'(i) == pos_reg)
            begin
                delta[8*i +: 8] = b;
            end
            else
            begin
                delta[8*i +: 8] = {8{b[7]}};
            end
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        len_left_next   = len_left_reg;
        off_left_next   = off_left_reg;
        off_total_next  = off_total_reg;
        pos_next        = pos_reg;
        len_acc_next    = len_acc_reg;
        delta_acc_next  = delta_acc_reg;
        cluster_next    = cluster_reg;
        counter_next    = counter_reg;

        out_valid_next  = out_valid_reg && !run_out.ready;
        out_len_next    = out_len_reg;
        out_start_next  = out_start_reg;
        out_num_next    = out_num_reg;
        out_sparse_next = out_sparse_reg;
        out_end_next    = out_end_reg;
        out_bad_next    = out_bad_reg;

        if (fire)
        begin
            phase_next   = ph;
            cluster_next = cluster_base;
            counter_next = counter_base;

            out_num_next    = counter_base;
            out_len_next    = 64'd0;
            out_start_next  = 64'sd0;
            out_sparse_next = 1'b0;
            out_end_next    = 1'b0;
            out_bad_next    = 1'b0;

            unique case (ph)
                PH_HEADER:
                begin
                    if (b == rld_pkg::RLD_HDR_END)
                    begin
                        out_valid_next = 1'b1;
                        out_end_next   = 1'b1;
                        phase_next     = PH_IDLE;
                    end
                    else if (lnib > rld_pkg::RLD_NIB_MAX || onib > rld_pkg::RLD_NIB_MAX)
                    begin
                        out_valid_next = 1'b1;
                        out_bad_next   = 1'b1;
                        phase_next     = PH_IDLE;
                    end
                    else
                    begin
                        len_left_next  = lnib;
                        off_left_next  = onib;
                        off_total_next = onib;
                        pos_next       = 3'd0;
                        len_acc_next   = 64'd0;
                        delta_acc_next = 64'd0;
                        phase_next     = (lnib != 4'd0) ? PH_LENGTH : PH_OFFSET;
                    end
                end
                PH_LENGTH:
                begin
                    len_acc_next  = len_acc_reg | byte_shifted;
                    pos_next      = pos_reg + 3'd1;
                    len_left_next = len_left_reg - 4'd1;
                    if (len_left_next == 4'd0)
                    begin
                        pos_next = 3'd0;
                        if (off_total_reg != 4'd0)
                        begin
                            phase_next = PH_OFFSET;
                        end
                        else
                        begin
                            out_valid_next  = 1'b1;
                            out_len_next    = len_acc_next;
                            out_sparse_next = 1'b1;
                            counter_next    = counter_adv;
                            phase_next      = PH_HEADER;
                        end
                    end
                end
                PH_OFFSET:
                begin
                    delta_acc_next = delta_acc_reg | byte_shifted;
                    pos_next       = pos_reg + 3'd1;
                    off_left_next  = off_left_reg - 4'd1;
                    if (off_left_next == 4'd0)
                    begin
                        pos_next       = 3'd0;
                        cluster_next   = cluster_base + delta;
                        out_valid_next = 1'b1;
                        out_len_next   = len_acc_reg;
                        out_start_next = cluster_next;
                        counter_next   = counter_adv;
                        phase_next     = PH_HEADER;
                    end
                end
                PH_IDLE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            len_left_reg   <= 4'd0;
            off_left_reg   <= 4'd0;
            off_total_reg  <= 4'd0;
            pos_reg        <= 3'd0;
            len_acc_reg    <= 64'd0;
            delta_acc_reg  <= 64'd0;
            cluster_reg    <= 64'd0;
            counter_reg    <= 7'd0;
            out_valid_reg  <= 1'b0;
            out_len_reg    <= 64'd0;
            out_start_reg  <= 64'sd0;
            out_num_reg    <= 7'd0;
            out_sparse_reg <= 1'b0;
            out_end_reg    <= 1'b0;
            out_bad_reg    <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            len_left_reg   <= len_left_next;
            off_left_reg   <= off_left_next;
            off_total_reg  <= off_total_next;
            pos_reg        <= pos_next;
            len_acc_reg    <= len_acc_next;
            delta_acc_reg  <= delta_acc_next;
            cluster_reg    <= cluster_next;
            counter_reg    <= counter_next;
            out_valid_reg  <= out_valid_next;
            out_len_reg    <= out_len_next;
            out_start_reg  <= out_start_next;
            out_num_reg    <= out_num_next;
            out_sparse_reg <= out_sparse_next;
            out_end_reg    <= out_end_next;
            out_bad_reg    <= out_bad_next;
        end
    end

    assign run_out.valid             = out_valid_reg;
    assign run_out.run_length        = out_len_reg;
    assign run_out.run_start_cluster = out_start_reg;
    assign run_out.run_number        = out_num_reg;
    assign run_out.sparse_run        = out_sparse_reg;
    assign run_out.list_end          = out_end_reg;
    assign run_out.bad_header        = out_bad_reg;

endmodule

`default_nettype wire

// ----- sv/ntfs_run_list_decoder.sv -----
// Channel   Direction  Payload
// run_in    sink       run_byte[7:0], list_start
// run_out   source     run_length[63:0], run_start_cluster[63:0] (signed), run_number[6:0],
//                      sparse_run, list_end, bad_header
//
// One byte is accepted per cycle unless a result stalls; a byte that completes a run,
// ends the list or carries a bad header is taken from the input register into a result.
// The 64-bit start cluster add and byte merge sit between the input register and
// the result register, which together set the one-byte-per-cycle rate.
// rst_n clears all decoder state; the decoder then expects a header.
// A stalled result holds in the result register while the input register still fills.

`default_nettype none

module ntfs_run_list_decoder #(
    parameter int unsigned MAX_RUNS = rld_pkg::RLD_MAX_RUNS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    rld_in_if.sink    run_in,
    rld_out_if.source run_out
);

    localparam logic [6:0] RUN_CAP = 7'((MAX_RUNS - 1 > rld_pkg::RLD_RUN_NUM_MAX)
                                        ? rld_pkg::RLD_RUN_NUM_MAX : MAX_RUNS - 1);

    rld_pkg::item_t item;
    logic           item_valid;
    logic           item_take;

    rld_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .run_in     (run_in),
        .item_take  (item_take),
        .item       (item),
        .item_valid (item_valid)
    );

    rld_core #(
        .RUN_CAP (RUN_CAP)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .run_out    (run_out)
    );

endmodule

`default_nettype wire

// ----- verif/rld_tb_pkg.sv -----
package rld_tb_pkg;

    import rld_pkg::*;

    // Highest run number the decoder reaches before it stops counting.
    localparam int unsigned RUN_COUNT_CAP =
        (RLD_MAX_RUNS - 1 < RLD_RUN_NUM_MAX) ? RLD_MAX_RUNS - 1 : RLD_RUN_NUM_MAX;

    typedef enum logic [1:0] {
        DEC_HEADER,
        DEC_LENGTH,
        DEC_OFFSET,
        DEC_IDLE
    } dec_phase_t;

    typedef struct packed {
        logic [63:0]        run_length;
        logic signed [63:0] run_start_cluster;
        logic [6:0]         run_number;
        logic               sparse_run;
        logic               list_end;
        logic               bad_header;
    } run_result_t;

    class run_decode_board;
        dec_phase_t  phase;
        logic [3:0]  length_left;
        logic [3:0]  offset_left;
        logic [3:0]  offset_total;
        logic [2:0]  byte_pos;
        logic [63:0] length_acc;
        logic [63:0] delta_acc;
        logic [63:0] cluster;
        logic [6:0]  run_count;
        run_result_t pending[$];
        int          errors;

        function new();
            phase        = DEC_HEADER;
            length_left  = '0;
            offset_left  = '0;
            offset_total = '0;
            byte_pos     = '0;
            length_acc   = '0;
            delta_acc    = '0;
            cluster      = '0;
            run_count    = '0;
            errors       = 0;
        endfunction

        function void bump_run_count();
            if (run_count < RUN_COUNT_CAP)
            begin
                run_count = run_count + 7'd1;
            end
        endfunction

        // Updates the decoder state for one accepted byte and queues the result
        // it causes. Returns 0 when the decoder ignores the byte.
        function bit note_byte(logic [7:0] data, logic start);
            run_result_t r;
            logic [63:0] delta;
            int unsigned bits;
            r = '0;
            if (start)
            begin
                cluster   = '0;
                run_count = '0;
                phase     = DEC_HEADER;
            end
            case (phase)
                DEC_HEADER:
                begin
                    if (data == RLD_HDR_END)
                    begin
                        r.list_end   = 1'b1;
                        r.run_number = run_count;
                        pending.push_back(r);
                        phase = DEC_IDLE;
                    end
                    else if (data[3:0] > RLD_NIB_MAX || data[7:4] > RLD_NIB_MAX)
                    begin
                        r.bad_header = 1'b1;
                        r.run_number = run_count;
                        pending.push_back(r);
                        phase = DEC_IDLE;
                    end
                    else
                    begin
                        length_left  = data[3:0];
                        offset_left  = data[7:4];
                        offset_total = data[7:4];
                        byte_pos     = '0;
                        length_acc   = '0;
                        delta_acc    = '0;
                        phase = (data[3:0] != 4'd0) ? DEC_LENGTH : DEC_OFFSET;
                    end
                    return 1'b1;
                end
                DEC_LENGTH:
                begin
                    length_acc  = length_acc | ({56'd0, data} << (8 * byte_pos));
                    byte_pos    = byte_pos + 3'd1;
                    length_left = length_left - 4'd1;
                    if (length_left == 4'd0)
                    begin
                        byte_pos = '0;
                        if (offset_total != 4'd0)
                        begin
                            phase = DEC_OFFSET;
                        end
                        else
                        begin
                            // A run without offset bytes is sparse and leaves the
                            // running cluster alone.
                            r.run_length = length_acc;
                            r.sparse_run = 1'b1;
                            r.run_number = run_count;
                            pending.push_back(r);
                            bump_run_count();
                            phase = DEC_HEADER;
                        end
                    end
                    return 1'b1;
                end
                DEC_OFFSET:
                begin
                    delta_acc   = delta_acc | ({56'd0, data} << (8 * byte_pos));
                    byte_pos    = byte_pos + 3'd1;
                    offset_left = offset_left - 4'd1;
                    if (offset_left == 4'd0)
                    begin
                        byte_pos = '0;
                        delta    = delta_acc;
                        if (offset_total < 4'd8)
                        begin
                            bits = 8 * offset_total;
                            if (delta[bits - 1])
                            begin
                                delta = delta | ({64{1'b1}} << bits);
                            end
                        end
                        cluster = cluster + delta;
                        r.run_length        = length_acc;
                        r.run_start_cluster = cluster;
                        r.run_number        = run_count;
                        pending.push_back(r);
                        bump_run_count();
                        phase = DEC_HEADER;
                    end
                    return 1'b1;
                end
                default:
                begin
                    return 1'b0;
                end
            endcase
        endfunction

        function void field_diff(string name, logic [63:0] want, logic [63:0] got,
                                 realtime now);
            if (want !== got)
            begin
                $display("%0.3f ns: %s mismatch, expected %h, actual %h",
                         now, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(run_result_t got, realtime now);
            run_result_t want;
            if (pending.size() == 0)
            begin
                $display("%0.3f ns: unexpected result, expected none, actual %h", now, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            field_diff("run_length", want.run_length, got.run_length, now);
            field_diff("run_start_cluster", want.run_start_cluster,
                       got.run_start_cluster, now);
            field_diff("run_number", 64'(want.run_number), 64'(got.run_number), now);
            field_diff("sparse_run", 64'(want.sparse_run), 64'(got.sparse_run), now);
            field_diff("list_end", 64'(want.list_end), 64'(got.list_end), now);
            field_diff("bad_header", 64'(want.bad_header), 64'(got.bad_header), now);
        endfunction
    endclass

endpackage

// ----- verif/testbench.sv -----
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import rld_pkg::*;
    import rld_tb_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic clk;
    logic rst_n;
    int   send_idle;
    int   recv_idle;
    int   taken;
    int   quiet_cycles;

    run_decode_board board;

    rld_in_if  run_in ();
    rld_out_if run_out ();

    ntfs_run_list_decoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .run_in  (run_in),
        .run_out (run_out)
    );

    wire in_xfer  = run_in.valid && run_in.ready;
    wire out_xfer = run_out.valid && run_out.ready;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // One transfer on the input side, with a random number of idle cycles ahead.
    task automatic send_byte(input logic [7:0] data, input logic start);
        while ($urandom_range(0, 99) < send_idle)
        begin
            run_in.valid <= 1'b0;
            @(posedge clk);
        end
        run_in.valid      <= 1'b1;
        run_in.run_byte   <= data;
        run_in.list_start <= start;
        @(posedge clk);
        while (!run_in.ready)
        begin
            @(posedge clk);
        end
        if (board.note_byte(data, start))
        begin
            taken++;
        end
    endtask

    function automatic logic [7:0] content_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 3);
        repeat (n)
        begin
            send_byte(content_byte(), 1'b0);
        end
    endtask

    // Sends one run list. With short_runs set, the list uses the smallest runs so
    // that the run number saturates quickly.
    task automatic send_list(input int runs, input bit short_runs);
        logic       first;
        logic [3:0] lnib;
        logic [3:0] onib;
        logic [7:0] hdr;
        int         cut;
        int         k;
        first = ($urandom_range(0, 9) != 0);
        for (int i = 0; i < runs; i++)
        begin
            if (short_runs)
            begin
                case ($urandom_range(0, 2))
                    0:       hdr = 8'h01;
                    1:       hdr = 8'h10;
                    default: hdr = 8'h11;
                endcase
            end
            else
            begin
                lnib = 4'($urandom_range(0, 8));
                onib = 4'($urandom_range(0, 8));
                if (lnib == 4'd0 && onib == 4'd0)
                begin
                    lnib = 4'd1;
                end
                if ($urandom_range(0, 39) == 0)
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        lnib = 4'($urandom_range(9, 15));
                    end
                    else
                    begin
                        onib = 4'($urandom_range(9, 15));
                    end
                end
                hdr = {onib, lnib};
            end
            send_byte(hdr, first);
            first = 1'b0;
            if (hdr[3:0] > RLD_NIB_MAX || hdr[7:4] > RLD_NIB_MAX)
            begin
                send_noise();
                return;
            end
            cut = -1;
            if (!short_runs && $urandom_range(0, 39) == 0)
            begin
                cut = $urandom_range(0, hdr[3:0] + hdr[7:4] - 1);
            end
            for (k = 0; k < hdr[3:0] + hdr[7:4]; k++)
            begin
                // Leave the run unfinished; the next list start drops it.
                if (k == cut)
                begin
                    return;
                end
                send_byte(content_byte(), 1'b0);
            end
        end
        if ($urandom_range(0, 9) != 0)
        begin
            send_byte(RLD_HDR_END, first);
        end
        if ($urandom_range(0, 4) == 0)
        begin
            send_noise();
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_xfer)
        begin
            board.check_result({run_out.run_length, run_out.run_start_cluster,
                                run_out.run_number, run_out.sparse_run,
                                run_out.list_end, run_out.bad_header}, $realtime);
        end
        run_out.ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_xfer || out_xfer)
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        run_in.valid      = 1'b0;
        run_in.run_byte   = 8'h00;
        run_in.list_start = 1'b0;
        run_out.ready     = 1'b0;
        send_idle         = 17;
        recv_idle         = 53;
        taken             = 0;
        quiet_cycles      = 0;
        board             = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A list may begin without a list start after reset.
        send_byte(8'h11, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h05, 1'b0);
        // Header with no length bytes.
        send_byte(8'h10, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(RLD_HDR_END, 1'b0);
        // Ignored while the list is closed; the two list starts after it carry bad headers.
        send_byte(8'h37, 1'b0);
        send_byte(8'h09, 1'b1);
        send_byte(8'h90, 1'b1);
        // A restart in the middle of a run drops the partial run.
        send_byte(8'h21, 1'b1);
        send_byte(8'h42, 1'b0);
        send_byte(8'h12, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(RLD_HDR_END, 1'b0);

        while (taken < 330)
        begin
            send_list($urandom_range(0, 8), 1'b0);
        end

        send_idle = 53;
        recv_idle = 17;
        send_list(140, 1'b1);
        while (taken < 650)
        begin
            send_list($urandom_range(0, 8), 1'b0);
        end

        send_idle = 0;
        recv_idle = 0;
        while (taken < 967)
        begin
            send_list($urandom_range(0, 8), 1'b0);
        end
        run_in.valid <= 1'b0;

        while (board.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.errors == 0 && board.pending.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/rld_pkg.sv
sv/rld_in_if.sv
sv/rld_out_if.sv
sv/rld_in_stage.sv
sv/rld_core.sv
sv/ntfs_run_list_decoder.sv
verif/rld_tb_pkg.sv
verif/testbench.sv
